// ===== hdl/assert_macros.svh =====
// assertion macros used by the solver top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// implication checked at every clock edge outside reset
`define QRS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// condition must never hold at a clock edge outside reset
`define QRS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define QRS_ASSERT(lbl, clk, rst_n, prop)
`define QRS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hdl/qrs_pkg.sv =====
// types and constants of the quadratic root solver
`timescale 1ns / 1ps
package qrs_pkg;
    localparam int COEF_W = 32;
    localparam int DEN_W  = 33;
    localparam int DISC_W = 68;
    localparam int ROOT_W = 34;
    localparam int MAG_W  = 35;
    localparam int REM_W  = 38;

    // per item data carried alongside the discriminant and root
    typedef struct packed {
        logic signed [COEF_W-1:0] coef_b;
        logic                     a_neg;
        logic [DEN_W-1:0]         den_mag;
        logic                     ok;
    } side_t;

    // per quotient tag carried through a divider
    typedef struct packed {
        logic ok;
        logic neg;
    } div_tag_t;
endpackage

// ===== hdl/qrs_front.sv =====
// magnitudes, products and discriminant in three register stages
`timescale 1ns / 1ps
module qrs_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_vld,
    input  logic signed [qrs_pkg::COEF_W-1:0]   coef_a,
    input  logic signed [qrs_pkg::COEF_W-1:0]   coef_b,
    input  logic signed [qrs_pkg::COEF_W-1:0]   coef_c,
    input  logic [30:0]                         min_leading_term,
    output logic                                out_vld,
    output logic [qrs_pkg::DISC_W-1:0]          disc,
    output qrs_pkg::side_t                      side
);
    localparam int CW = qrs_pkg::COEF_W;

    logic          v1_reg, v2_reg, v3_reg;
    logic [CW-1:0] am_reg, bm_reg, cm_reg;
    logic          acn1_reg, acn2_reg;
    qrs_pkg::side_t s1_reg, s2_reg, s3_reg;
    logic [2*CW-1:0] b2_reg, ac_reg;
    logic [qrs_pkg::DISC_W-1:0] disc_reg;

    logic [CW-1:0] am, bm, cm;
    logic [qrs_pkg::DEN_W-1:0] den;
    logic [2*CW+1:0] ac4;
    logic [qrs_pkg::DISC_W-1:0] disc_next;
    qrs_pkg::side_t s3_next;

    // stage one: magnitudes and threshold test
    always_comb begin
        am  = coef_a[CW-1] ? CW'(-coef_a) : CW'(coef_a);
        bm  = coef_b[CW-1] ? CW'(-coef_b) : CW'(coef_b);
        cm  = coef_c[CW-1] ? CW'(-coef_c) : CW'(coef_c);
        den = {am, 1'b0};
    end

    // stage three: discriminant, negative means no roots
    always_comb begin
        ac4 = {ac_reg, 2'b00};
        s3_next = s2_reg;
        disc_next = '0;
        if (acn2_reg) begin
            disc_next = qrs_pkg::DISC_W'(b2_reg) + qrs_pkg::DISC_W'(ac4);
        end else if (ac4 > (2*CW+2)'(b2_reg)) begin
            s3_next.ok = 1'b0;
        end else begin
            disc_next = qrs_pkg::DISC_W'((2*CW+2)'(b2_reg) - ac4);
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (en) begin
            am_reg         <= am;
            bm_reg         <= bm;
            cm_reg         <= cm;
            acn1_reg       <= coef_a[CW-1] ^ coef_c[CW-1];
            s1_reg.coef_b  <= coef_b;
            s1_reg.a_neg   <= coef_a[CW-1];
            s1_reg.den_mag <= den;
            s1_reg.ok      <= (am != '0) && (den >= qrs_pkg::DEN_W'(min_leading_term));
            b2_reg         <= bm_reg * bm_reg;
            ac_reg         <= am_reg * cm_reg;
            acn2_reg       <= acn1_reg;
            s2_reg         <= s1_reg;
            disc_reg       <= disc_next;
            s3_reg         <= s3_next;
        end
    end

    assign out_vld = v3_reg;
    assign disc    = disc_reg;
    assign side    = s3_reg;
endmodule

// ===== hdl/qrs_sqrt.sv =====
// integer square root, one result bit per pipeline stage
`timescale 1ns / 1ps
module qrs_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [qrs_pkg::DISC_W-1:0]    radicand,
    input  qrs_pkg::side_t                in_side,
    output logic                          out_vld,
    output logic [qrs_pkg::ROOT_W-1:0]    root,
    output qrs_pkg::side_t                out_side
);
    localparam int N  = qrs_pkg::ROOT_W;
    localparam int RW = qrs_pkg::REM_W;
    localparam int DW = qrs_pkg::DISC_W;

    logic           vld_reg  [N];
    logic [DW-1:0]  rad_reg  [N];
    logic [RW-1:0]  rem_reg  [N];
    logic [N-1:0]   res_reg  [N];
    qrs_pkg::side_t side_reg [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic           v_in;
        logic [DW-1:0]  rad_in;
        logic [RW-1:0]  rem_in;
        logic [N-1:0]   res_in;
        qrs_pkg::side_t side_in;
        logic [RW-1:0]  rem_s, trial;
        logic           ge;

        if (k == 0) begin : g_first
            assign v_in    = in_vld;
            assign rad_in  = radicand;
            assign rem_in  = '0;
            assign res_in  = '0;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = vld_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign res_in  = res_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // bring down the next bit pair and try the trial subtraction
        always_comb begin
            rem_s = {rem_in[RW-3:0], rad_in[DW-1:DW-2]};
            trial = {{(RW-N-2){1'b0}}, res_in, 2'b01};
            ge    = rem_s >= trial;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k]  <= {rad_in[DW-3:0], 2'b00};
                rem_reg[k]  <= ge ? rem_s - trial : rem_s;
                res_reg[k]  <= {res_in[N-2:0], ge};
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign root     = res_reg[N-1];
    assign out_side = side_reg[N-1];
endmodule

// ===== hdl/qrs_div.sv =====
// restoring divider, one quotient bit per pipeline stage
`timescale 1ns / 1ps
module qrs_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_vld,
    input  logic [qrs_pkg::MAG_W-1:0]              num_mag,
    input  logic [qrs_pkg::DEN_W-1:0]              den_mag,
    input  qrs_pkg::div_tag_t                      in_tag,
    output logic                                   out_vld,
    output logic [qrs_pkg::MAG_W+FRAC_BITS-1:0]    quot,
    output qrs_pkg::div_tag_t                      out_tag
);
    localparam int NW = qrs_pkg::MAG_W + FRAC_BITS;
    localparam int DW = qrs_pkg::DEN_W;

    logic              vld_reg [NW];
    logic [NW-1:0]     num_reg [NW];
    logic [NW-1:0]     q_reg   [NW];
    logic [DW-1:0]     rem_reg [NW];
    logic [DW-1:0]     den_reg [NW];
    qrs_pkg::div_tag_t tag_reg [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic              v_in;
        logic [NW-1:0]     num_in, q_in;
        logic [DW-1:0]     rem_in, den_in;
        qrs_pkg::div_tag_t tag_in;
        logic [DW:0]       rem_s;
        logic              ge;

        if (k == 0) begin : g_first
            assign v_in   = in_vld;
            assign num_in = {num_mag, {FRAC_BITS{1'b0}}};
            assign q_in   = '0;
            assign rem_in = '0;
            assign den_in = den_mag;
            assign tag_in = in_tag;
        end else begin : g_next
            assign v_in   = vld_reg[k-1];
            assign num_in = num_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign tag_in = tag_reg[k-1];
        end

        // shift in the next numerator bit and compare with the divisor
        always_comb begin
            rem_s = {rem_in, num_in[NW-1]};
            ge    = rem_s >= {1'b0, den_in};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[k] <= {num_in[NW-2:0], 1'b0};
                q_reg[k]   <= {q_in[NW-2:0], ge};
                rem_reg[k] <= ge ? DW'(rem_s - {1'b0, den_in}) : DW'(rem_s);
                den_reg[k] <= den_in;
                tag_reg[k] <= tag_in;
            end
        end
    end

    assign out_vld = vld_reg[NW-1];
    assign quot    = q_reg[NW-1];
    assign out_tag = tag_reg[NW-1];
endmodule

// ===== hdl/quadratic_root_solver.sv =====
// Real roots of a*t^2 + b*t + c = 0 in signed fixed point, fully pipelined.
// Input transactions on s_tvalid/s_tready carry a, b and c in s_tdata.
// Result transactions on m_tvalid/m_tready carry both roots in m_tdata and the
// valid and saturation flags in m_tuser; exactly one result per input item.
// The threshold on |2a| must be written over cfg_valid/cfg_ready only while idle,
// which the block itself does not enforce. The pipeline has three stages for
// magnitudes, products and discriminant, 34 square root stages, one numerator
// stage, 35 + FRAC_BITS divider stages and the output register.
// Throughput is one item per cycle unless the receiver stalls; the square root
// and divider pipelines, one bit per stage, set the latency, never the rate.
// Reset clears all valid bits and loads the threshold with 2^FRAC_BITS/100.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops in the same cycle; nothing is lost or repeated, and
// input is taken again as soon as the waiting result is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module quadratic_root_solver #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data,   // min_leading_term
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,    // coef_a [31:0], coef_b [63:32], coef_c [95:64]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // root_plus [31:0], root_minus [63:32]
    output logic [1:0]  m_tuser     // roots_valid [0], root_saturated [1]
);
    localparam int NW = qrs_pkg::MAG_W + FRAC_BITS;
    localparam int SW = qrs_pkg::MAG_W + 1;
    localparam logic [30:0] THR_RESET = 31'((64'd1 << FRAC_BITS) / 100);

    logic        en;
    logic [30:0] thr_reg;

    logic                          f_vld;
    logic [qrs_pkg::DISC_W-1:0]    f_disc;
    qrs_pkg::side_t                f_side;
    logic                          r_vld;
    logic [qrs_pkg::ROOT_W-1:0]    r_root;
    qrs_pkg::side_t                r_side;

    logic signed [SW-1:0]          nb, np, nm;
    logic                          n_vld_reg;
    logic [qrs_pkg::MAG_W-1:0]     magp_reg, magm_reg;
    logic [qrs_pkg::DEN_W-1:0]     den_reg;
    qrs_pkg::div_tag_t             tagp_reg, tagm_reg;

    logic                          dp_vld, dm_vld;
    logic [NW-1:0]                 qp, qm;
    qrs_pkg::div_tag_t             tp, tm;

    logic [31:0] rp, rm;
    logic        satp, satm;
    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    // whole pipeline moves unless a result waits unclaimed
    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    qrs_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (en),
        .in_vld           (s_tvalid),
        .coef_a           (s_tdata[31:0]),
        .coef_b           (s_tdata[63:32]),
        .coef_c           (s_tdata[95:64]),
        .min_leading_term (thr_reg),
        .out_vld          (f_vld),
        .disc             (f_disc),
        .side             (f_side)
    );

    qrs_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (f_vld),
        .radicand (f_disc),
        .in_side  (f_side),
        .out_vld  (r_vld),
        .root     (r_root),
        .out_side (r_side)
    );

    // numerators -b + root and -b - root, split into sign and magnitude
    always_comb begin
        nb = -SW'(r_side.coef_b);
        np = nb + SW'(r_root);
        nm = nb - SW'(r_root);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_vld_reg <= 1'b0;
        end else if (en) begin
            n_vld_reg <= r_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            magp_reg     <= np[SW-1] ? qrs_pkg::MAG_W'(-np) : qrs_pkg::MAG_W'(np);
            magm_reg     <= nm[SW-1] ? qrs_pkg::MAG_W'(-nm) : qrs_pkg::MAG_W'(nm);
            den_reg      <= r_side.den_mag;
            tagp_reg.ok  <= r_side.ok;
            tagp_reg.neg <= np[SW-1] ^ r_side.a_neg;
            tagm_reg.ok  <= r_side.ok;
            tagm_reg.neg <= nm[SW-1] ^ r_side.a_neg;
        end
    end

    qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div_plus (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (n_vld_reg),
        .num_mag (magp_reg),
        .den_mag (den_reg),
        .in_tag  (tagp_reg),
        .out_vld (dp_vld),
        .quot    (qp),
        .out_tag (tp)
    );

    qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div_minus (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (n_vld_reg),
        .num_mag (magm_reg),
        .den_mag (den_reg),
        .in_tag  (tagm_reg),
        .out_vld (dm_vld),
        .quot    (qm),
        .out_tag (tm)
    );

    // sign and saturation of both quotients
    always_comb begin
        satp = tp.neg ? (qp > NW'(33'h0_8000_0000)) : (qp > NW'(33'h0_7FFF_FFFF));
        satm = tm.neg ? (qm > NW'(33'h0_8000_0000)) : (qm > NW'(33'h0_7FFF_FFFF));
        if (satp) begin
            rp = tp.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            rp = tp.neg ? -qp[31:0] : qp[31:0];
        end
        if (satm) begin
            rm = tm.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            rm = tm.neg ? -qm[31:0] : qm[31:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dp_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (tp.ok) begin
                m_tdata_reg <= {rm, rp};
                m_tuser_reg <= {satp || satm, 1'b1};
            end else begin
                m_tdata_reg <= '0;
                m_tuser_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // both dividers run in lockstep
    `QRS_ASSERT(a_div_lockstep, aclk, aresetn, dp_vld == dm_vld)
    // an invalid result carries zero roots and no saturation
    `QRS_ASSERT(a_invalid_zero, aclk, aresetn, (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
    // input is refused only while a result waits unclaimed
    `QRS_ASSERT_NEVER(a_ready_stall, aclk, aresetn, !s_tready && !(m_tvalid && !m_tready))
endmodule

// ===== dv/testbench.sv =====
// self-checking testbench of the quadratic root solver
`timescale 1ns / 1ps
module testbench;
    localparam int FRAC = 16;
    localparam int LATENCY = 74 + FRAC;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1300;

    // one root transaction
    typedef struct {
        logic signed [31:0] plus;
        logic signed [31:0] minus;
        logic               valid;
        logic               sat;
    } roots_t;

    // directed stimulus row; check_fixed uses the typed-in result
    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        bit          check_fixed;
        roots_t      fixed;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [30:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    roots_t      roots_due[$];
    logic [30:0] threshold;
    int          errors;
    int          results_seen;
    int          valid_seen;
    int          sat_seen;
    longint      cycles;
    bit          hold_off;
    bit          random_phase;

    quadratic_root_solver #(.FRAC_BITS(FRAC)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // cycle limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic logic [33:0] wide_isqrt(logic [67:0] radicand);
        logic [35:0] rem;
        logic [35:0] trial;
        logic [33:0] res;
        rem = '0;
        res = '0;
        for (int i = 33; i >= 0; i--) begin
            rem = (rem << 2) | radicand[2*i +: 2];
            trial = {res, 2'b01};
            if (rem >= trial) begin
                rem = rem - trial;
                res = {res[32:0], 1'b1};
            end else begin
                res = {res[32:0], 1'b0};
            end
        end
        return res;
    endfunction

    // truncated quotient num * 2^FRAC / den, clipped to 32 bits
    function automatic logic [31:0] clipped_quotient(logic signed [35:0] num, bit den_neg,
                                                     logic [32:0] den_mag, inout bit sat);
        logic [35:0] num_mag;
        logic [63:0] q;
        bit          neg;
        num_mag = num < 0 ? -num : num;
        q = {28'd0, num_mag} << FRAC;
        q = q / den_mag;
        neg = (num < 0) != den_neg;
        if (neg) begin
            if (q > 64'h8000_0000) begin
                q = 64'h8000_0000;
                sat = 1;
            end
            return -q[31:0];
        end
        if (q > 64'h7FFF_FFFF) begin
            q = 64'h7FFF_FFFF;
            sat = 1;
        end
        return q[31:0];
    endfunction

    function automatic roots_t solve_roots(logic signed [31:0] a, logic signed [31:0] b,
                                           logic signed [31:0] c);
        roots_t           r;
        logic signed [67:0] disc;
        logic [32:0]      den_mag;
        logic [33:0]      root;
        logic signed [35:0] nb;
        bit               sat;
        r = '{0, 0, 0, 0};
        den_mag = a < 0 ? 33'(-34'(a)) << 1 : 33'(a) << 1;
        disc = 68'(b) * 68'(b) - 68'sd4 * 68'(a) * 68'(c);
        if (a == 0 || den_mag < {2'b00, threshold} || disc < 0) return r;
        root = wide_isqrt(disc);
        nb = -36'(b);
        sat = 0;
        r.plus = clipped_quotient(nb + 36'(root), a < 0, den_mag, sat);
        r.minus = clipped_quotient(nb - 36'(root), a < 0, den_mag, sat);
        r.valid = 1;
        r.sat = sat;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        if (errors <= 30)
            $display("mismatch %s: got %h expected %h (result %0d)", what, got, want,
                     results_seen);
    endtask

    // result checking at the rising edge
    always @(posedge aclk) begin
        roots_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (roots_due.size() == 0) begin
                report_mismatch("unexpected transaction", m_tdata[31:0], 0);
            end else begin
                want = roots_due.pop_front();
                if (m_tdata[31:0] !== want.plus)
                    report_mismatch("root_plus", m_tdata[31:0], want.plus);
                if (m_tdata[63:32] !== want.minus)
                    report_mismatch("root_minus", m_tdata[63:32], want.minus);
                if (m_tuser[0] !== want.valid)
                    report_mismatch("roots_valid", 32'(m_tuser[0]), 32'(want.valid));
                if (m_tuser[1] !== want.sat)
                    report_mismatch("root_saturated", 32'(m_tuser[1]), 32'(want.sat));
                valid_seen += int'(m_tuser[0]);
                sat_seen += int'(m_tuser[1]);
            end
            results_seen++;
        end
    end

    // receiver stall pattern, with a long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off) begin
            m_tready <= 1'b0;
        end else begin
            case ((cycles / 500) % 3)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // long hold-off while the sender keeps offering random items
    initial begin
        hold_off = 0;
        wait (random_phase);
        repeat (200) @(posedge aclk);
        hold_off = 1;
        repeat (LATENCY * 3) @(posedge aclk);
        hold_off = 0;
    end

    task automatic write_threshold(logic [30:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        threshold = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (roots_due.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    // offer one item, idling a random time first whenever a burst has ended
    task automatic send_item(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                             bit check_fixed, roots_t fixed, ref int burst);
        if (burst == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {c, b, a};
        do @(posedge aclk); while (!s_tready);
        roots_due.push_back(check_fixed ? fixed : solve_roots(a, b, c));
        burst--;
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
            2: return 32'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23);
            3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            4: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return 32'($signed($urandom_range(0, 2 ** 18)) - 2 ** 17) <<< 8;
        endcase
    endfunction

    localparam roots_t NONE = '{0, 0, 0, 0};
    localparam logic [31:0] ONE = 32'h0001_0000;

    row_t rows[$];
    int   burst;
    logic [31:0] a, b, c;
    logic [30:0] settings[4];

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        errors = 0;
        results_seen = 0;
        valid_seen = 0;
        sat_seen = 0;
        random_phase = 0;
        threshold = 31'((1 << FRAC) / 100);
        burst = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows after reset
        rows = '{
            '{0, ONE, ONE, 1, NONE},                                  // zero leading term
            '{32'd200, 0, 0, 1, NONE},                                // below reset threshold
            '{ONE, 0, ONE, 1, NONE},                                  // negative discriminant
            '{ONE, 0, 32'hFFFF_0000, 1, '{ONE, 32'hFFFF_0000, 1, 0}}, // t^2-1: +-1
            '{ONE, 32'hFFFE_0000, ONE, 1, '{ONE, ONE, 1, 0}},         // double root
            '{ONE, 0, 0, 1, '{0, 0, 1, 0}},
            '{32'hFFFF_0000, 0, ONE, 0, NONE},                        // negative a
            '{32'd330, 32'h7FFF_FFFF, 0, 0, NONE},                    // saturation
            '{32'd327, 0, 0, 1, NONE},                                // just under threshold
            '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, NONE},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, NONE},
            '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, NONE},
            '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, NONE},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, NONE},
            '{ONE, 32'h0003_0000, 32'h0002_0000, 0, NONE},
            '{32'h0000_8000, 32'h0001_8000, 32'hFFFF_C000, 0, NONE},
            '{32'd1000, 32'h8000_0000, 32'd5, 0, NONE}
        };
        foreach (rows[i])
            send_item(rows[i].a, rows[i].b, rows[i].c, rows[i].check_fixed, rows[i].fixed,
                      burst);
        s_tvalid <= 1'b0;
        drain();

        // threshold zero: a == 0 still invalid, tiny a now valid
        write_threshold(0);
        send_item(0, 0, 0, 1, NONE, burst);
        send_item(32'd1, 32'd5, 32'hFFFF_FFF0, 0, NONE, burst);
        s_tvalid <= 1'b0;
        drain();

        // random part over several thresholds, extremes among them
        random_phase = 1;
        settings = '{31'd655, 31'h7FFF_FFFF, 31'd0, 31'(ONE)};
        for (int p = 0; p < 4; p++) begin
            write_threshold(p == 3 ? 31'($urandom_range(0, 2 ** 20)) : settings[p]);
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                a = rand_coef();
                b = rand_coef();
                c = rand_coef();
                // often build real roots: c of sign opposite to a
                if ($urandom_range(0, 2) == 0) c = (a[31] == c[31]) ? -c : c;
                send_item(a, b, c, 0, NONE, burst);
            end
            s_tvalid <= 1'b0;
            drain();
        end

        $display("%0d results checked, %0d with real roots, %0d saturated",
                 results_seen, valid_seen, sat_seen);
        $display("thresholds covered: reset value, zero, maximum and random");
        if (errors == 0 && roots_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/qrs_pkg.sv
hdl/qrs_front.sv
hdl/qrs_sqrt.sv
hdl/qrs_div.sv
hdl/quadratic_root_solver.sv
dv/testbench.sv
